// ===== rtl/countdown_timer_bank_with_snooze_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the countdown timer bank
// Shared property wrappers, clocked on clk_i, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef COUNTDOWN_TIMER_BANK_WITH_SNOOZE_ASSERT_SVH
`define COUNTDOWN_TIMER_BANK_WITH_SNOOZE_ASSERT_SVH

// same-cycle implication
`define CTB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ctb_pkg.sv =====
// ----------------------------------------------------------------------------
// ctb_pkg
// Types and constants for the countdown timer bank.
// ----------------------------------------------------------------------------
`default_nettype none

package ctb_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned ValW   = 15;
  localparam int unsigned IdxW   = 4;

  localparam logic [CountW-1:0] IDLE_COUNT = 16'hFFFF;
  localparam logic [ValW-1:0]   SNOOZE_RST = 15'd300;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_LOAD   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_SNOOZE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_e;

  typedef struct packed {
    op_e             op;
    logic [IdxW-1:0] timer_index;
    logic [ValW-1:0] load_value;
  } in_t;

  typedef struct packed {
    logic            any_expired;
    logic [IdxW-1:0] first_expired;
    logic            snoozed;
  } out_t;

  // one timer update from the shared unit
  typedef struct packed {
    logic              we;
    logic [CountW-1:0] value;
    logic              zero;
  } upd_t;

endpackage

`default_nettype wire

// ===== rtl/ctb_alu.sv =====
// ----------------------------------------------------------------------------
// ctb_alu
// Shared update unit: decrement, load, clear or snooze of one timer and
// expiry test of the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ctb_alu (
  input  ctb_pkg::op_e                    op_i,
  input  logic [ctb_pkg::CountW-1:0]      cur_i,
  input  logic                            hit_i,
  input  logic                            found_i,
  input  logic [ctb_pkg::ValW-1:0]        load_value_i,
  input  logic [ctb_pkg::ValW-1:0]        snooze_ticks_i,
  output ctb_pkg::upd_t                   upd_o
);

  logic                       is_zero;
  logic                       running;
  logic                       we;
  logic [ctb_pkg::CountW-1:0] nv;
  logic [ctb_pkg::CountW-1:0] res;

  assign is_zero = (cur_i == '0);
  assign running = !is_zero && !cur_i[ctb_pkg::CountW-1];

  always_comb begin
    we = 1'b0;
    nv = cur_i;
    case (op_i)
      ctb_pkg::OP_TICK: begin
        we = running;
        nv = cur_i - ctb_pkg::CountW'(1);
      end
      ctb_pkg::OP_LOAD: begin
        we = hit_i;
        nv = {1'b0, load_value_i};
      end
      ctb_pkg::OP_CLEAR: begin
        we = hit_i;
        nv = ctb_pkg::IDLE_COUNT;
      end
      ctb_pkg::OP_SNOOZE: begin
        // only the lowest expired timer is reloaded
        we = is_zero && !found_i;
        nv = {1'b0, snooze_ticks_i};
      end
      default: begin
        we = 1'b0;
        nv = cur_i;
      end
    endcase
  end

  assign res         = we ? nv : cur_i;
  assign upd_o.we    = we;
  assign upd_o.value = nv;
  assign upd_o.zero  = (res == '0);

endmodule

`default_nettype wire

// ===== rtl/ctb_store.sv =====
// ----------------------------------------------------------------------------
// ctb_store
// Timer count memory, one write and one registered read port; entries not
// yet written read as idle.
// ----------------------------------------------------------------------------
`default_nettype none

module ctb_store #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [AddrW-1:0]           rd_addr_i,
  output logic [ctb_pkg::CountW-1:0] rd_data_o,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           wr_addr_i,
  input  logic [ctb_pkg::CountW-1:0] wr_data_i
);

  logic [ctb_pkg::CountW-1:0] mem [Depth];
  logic [Depth-1:0]           valid_q;
  logic [ctb_pkg::CountW-1:0] rdata_q;
  logic                       rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rdata_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      rvalid_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : ctb_pkg::IDLE_COUNT;

endmodule

`default_nettype wire

// ===== rtl/countdown_timer_bank_with_snooze.sv =====
// ----------------------------------------------------------------------------
// countdown_timer_bank_with_snooze
// Bank of countdown timers with tick, load, clear and snooze, walked one
// timer per cycle through a shared update unit.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+--------------
//  in       | input     | in_valid_i / in_ready_o    | in_data_i
//  out      | output    | out_valid_o / out_ready_i  | out_data_o
//  cfg      | input     | cfg_we_i (no wait)         | cfg_wdata_i
//
//  An item reads the first timer, then takes one scan step per timer on
//  the single memory port; ready returns with the result.
//  Reset: all timers idle via per-entry valid bits, snooze period 300.
//  The result sits in an output register; a new item is accepted meanwhile
//  and only waits at its end if that register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module countdown_timer_bank_with_snooze #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  ctb_pkg::in_t               in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output ctb_pkg::out_t              out_data_o,
  input  logic                       cfg_we_i,
  input  logic [ctb_pkg::ValW-1:0]   cfg_wdata_i
);

  localparam int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CW = (IW > ctb_pkg::IdxW) ? IW : ctb_pkg::IdxW;
  localparam logic [IW-1:0] LastIdx = IW'(NUM_TIMERS - 1);

  ctb_pkg::state_e state_q, state_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic            found_q, found_d;
  logic [IW-1:0]   first_q, first_d;
  logic            snz_q, snz_d;
  ctb_pkg::in_t    item_q, item_d;
  logic [ctb_pkg::ValW-1:0] snooze_q;
  logic            out_valid_q;
  ctb_pkg::out_t   out_q, out_d;
  logic            out_load;
  logic            slot_free;

  logic [IW-1:0]              rd_addr;
  logic [ctb_pkg::CountW-1:0] rd_data;
  logic                       hit;
  ctb_pkg::upd_t              upd;
  logic                       mem_we;

  assign hit = (CW'(idx_q) == CW'(item_q.timer_index));

  ctb_alu u_alu (
    .op_i           (item_q.op),
    .cur_i          (rd_data),
    .hit_i          (hit),
    .found_i        (snz_q),
    .load_value_i   (item_q.load_value),
    .snooze_ticks_i (snooze_q),
    .upd_o          (upd)
  );

  ctb_store #(
    .Depth (NUM_TIMERS),
    .AddrW (IW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .we_i      (mem_we),
    .wr_addr_i (idx_q),
    .wr_data_i (upd.value)
  );

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ctb_pkg::ST_IDLE);

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    found_d  = found_q;
    first_d  = first_q;
    snz_d    = snz_q;
    item_d   = item_q;
    rd_addr  = '0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ctb_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          idx_d   = '0;
          found_d = 1'b0;
          first_d = '0;
          snz_d   = 1'b0;
          state_d = ctb_pkg::ST_SCAN;
        end
      end
      ctb_pkg::ST_SCAN: begin
        mem_we = upd.we;
        if (upd.zero && !found_q) begin
          found_d = 1'b1;
          first_d = idx_q;
        end
        if (upd.we && (item_q.op == ctb_pkg::OP_SNOOZE)) begin
          snz_d = 1'b1;
        end
        if (idx_q == LastIdx) begin
          if (slot_free) begin
            out_load = 1'b1;
            state_d  = ctb_pkg::ST_IDLE;
          end else begin
            state_d  = ctb_pkg::ST_HOLD;
          end
        end else begin
          idx_d   = idx_q + IW'(1);
          rd_addr = idx_q + IW'(1);
        end
      end
      ctb_pkg::ST_HOLD: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = ctb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ctb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d.any_expired   = found_d;
    out_d.first_expired = found_d ? ctb_pkg::IdxW'(first_d) : '0;
    out_d.snoozed       = snz_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ctb_pkg::ST_IDLE;
      idx_q       <= '0;
      found_q     <= 1'b0;
      first_q     <= '0;
      snz_q       <= 1'b0;
      snooze_q    <= ctb_pkg::SNOOZE_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      found_q <= found_d;
      first_q <= first_d;
      snz_q   <= snz_d;
      if (cfg_we_i) begin
        snooze_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/ctb_checker.sv =====
// ----------------------------------------------------------------------------
// ctb_checker
// Port-level checks for the countdown timer bank, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "countdown_timer_bank_with_snooze_assert.svh"

module ctb_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input ctb_pkg::out_t out_data_o
);

  // a waiting result transaction holds
  `CTB_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result dropped or changed while stalled")

  // one item at a time: busy right after an input transaction
  `CTB_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready high right after an accepted item")

  // no expired timer means index zero
  `CTB_ASSERT_NOW(a_first_zero, out_valid_o && !out_data_o.any_expired, out_data_o.first_expired == '0, "first_expired set with nothing expired")

endmodule

bind countdown_timer_bank_with_snooze ctb_checker u_ctb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ===== dv/timer_bank_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_bank_checker
// Watches the input, output and configuration ports of the countdown timer
// bank, keeps its own copy of the timers and the snooze period, predicts the
// status for every input transaction and compares each output transaction
// against the oldest prediction.
// ----------------------------------------------------------------------------
module timer_bank_checker #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  ctb_pkg::in_t               in_data_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  ctb_pkg::out_t              out_data_i,
  input  logic                       cfg_we_i,
  input  logic [ctb_pkg::ValW-1:0]   cfg_wdata_i,
  output int unsigned                fail_count_o,
  output int unsigned                pending_o
);

  logic [ctb_pkg::CountW-1:0] bank_count [NUM_TIMERS];
  logic [ctb_pkg::ValW-1:0]   snooze_period;
  ctb_pkg::out_t              status_q [$];
  int unsigned                fail_total;

  function automatic logic lowest_expired(output logic [ctb_pkg::IdxW-1:0] idx);
    logic hit;
    hit = 1'b0;
    idx = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (!hit && bank_count[i] == '0) begin
        hit = 1'b1;
        idx = i[ctb_pkg::IdxW-1:0];
      end
    end
    return hit;
  endfunction

  function automatic ctb_pkg::out_t apply_op(ctb_pkg::in_t txn);
    ctb_pkg::out_t            status;
    logic                     hit;
    logic [ctb_pkg::IdxW-1:0] idx;
    status = '0;
    case (txn.op)
      ctb_pkg::OP_TICK: begin
        // only positive counts run down; idle stays idle, zero stays expired
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (bank_count[i] != '0 && !bank_count[i][ctb_pkg::CountW-1]) begin
            bank_count[i] = bank_count[i] - ctb_pkg::CountW'(1);
          end
        end
      end
      ctb_pkg::OP_LOAD: begin
        if (txn.timer_index < NUM_TIMERS) begin
          bank_count[txn.timer_index] = {1'b0, txn.load_value};
        end
      end
      ctb_pkg::OP_CLEAR: begin
        if (txn.timer_index < NUM_TIMERS) begin
          bank_count[txn.timer_index] = ctb_pkg::IDLE_COUNT;
        end
      end
      default: begin
        if (lowest_expired(idx)) begin
          bank_count[idx] = {1'b0, snooze_period};
          status.snoozed  = 1'b1;
        end
      end
    endcase
    hit                  = lowest_expired(idx);
    status.any_expired   = hit;
    status.first_expired = hit ? idx : '0;
    return status;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ctb_pkg::out_t want;
    logic          bad;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        bank_count[i] = ctb_pkg::IDLE_COUNT;
      end
      snooze_period = ctb_pkg::SNOOZE_RST;
      status_q.delete();
      fail_total    = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        snooze_period = cfg_wdata_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (status_q.size() == 0) begin
          if (fail_total < 10) begin
            $display("%0t: unexpected status transaction any=%0d first=%0d snoozed=%0d",
                     $realtime, out_data_i.any_expired, out_data_i.first_expired,
                     out_data_i.snoozed);
          end
          fail_total++;
        end else begin
          want = status_q.pop_front();
          bad  = (out_data_i.any_expired   !== want.any_expired)   ||
                 (out_data_i.first_expired !== want.first_expired) ||
                 (out_data_i.snoozed       !== want.snoozed);
          if (bad) begin
            if (fail_total < 10) begin
              $display("%0t: status mismatch exp any=%0d first=%0d snoozed=%0d,",
                       $realtime, want.any_expired, want.first_expired, want.snoozed);
              $display("    got any=%0d first=%0d snoozed=%0d",
                       out_data_i.any_expired, out_data_i.first_expired,
                       out_data_i.snoozed);
            end
            fail_total++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        status_q.push_back(apply_op(in_data_i));
      end
      fail_count_o <= fail_total;
      pending_o    <= status_q.size();
    end
  end

endmodule

// ===== dv/tb_countdown_timer_bank_with_snooze.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_countdown_timer_bank_with_snooze
// Drives tick, load, clear and snooze transactions into the timer bank with
// random gaps and output stalls, across several snooze periods including the
// extremes, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_countdown_timer_bank_with_snooze;

  localparam int unsigned NumTimers     = 16;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned ItemsPerPhase = 370;
  localparam int unsigned SettleCycles  = 24;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  ctb_pkg::in_t             in_data_i   = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  ctb_pkg::out_t            out_data_o;
  logic                     cfg_we_i    = 1'b0;
  logic [ctb_pkg::ValW-1:0] cfg_wdata_i = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles = 0;
  bit          calm = 1'b0;

  always #2 clk_i = ~clk_i;

  countdown_timer_bank_with_snooze #(
    .NUM_TIMERS (NumTimers)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  timer_bank_checker #(
    .NUM_TIMERS (NumTimers)
  ) u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ctb_pkg::ValW-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 70) return ctb_pkg::ValW'($urandom_range(1, 12));
    if (r < 90) return ctb_pkg::ValW'($urandom_range(13, 200));
    return ctb_pkg::ValW'($urandom_range(0, 32767));
  endfunction

  task automatic send_txn(input ctb_pkg::op_e op, input logic [ctb_pkg::IdxW-1:0] idx,
                          input logic [ctb_pkg::ValW-1:0] val);
    ctb_pkg::in_t txn;
    int unsigned  gap;
    txn.op          = op;
    txn.timer_index = idx;
    txn.load_value  = val;
    in_valid_i <= 1'b1;
    in_data_i  <= txn;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random();
    int unsigned              r;
    logic [ctb_pkg::IdxW-1:0] idx;
    r   = $urandom_range(0, 99);
    idx = ctb_pkg::IdxW'($urandom_range(0, NumTimers - 1));
    if (r < 40) begin
      send_txn(ctb_pkg::OP_TICK, idx, pick_count());
    end else if (r < 70) begin
      send_txn(ctb_pkg::OP_LOAD, idx, pick_count());
    end else if (r < 80) begin
      send_txn(ctb_pkg::OP_CLEAR, idx, pick_count());
    end else begin
      send_txn(ctb_pkg::OP_SNOOZE, idx, pick_count());
    end
  endtask

  // input already lowered by the caller
  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_snooze(input logic [ctb_pkg::ValW-1:0] period);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= period;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // output back-pressure
  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      stall = calm ? 0 : pick_gap();
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= StallLimit);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [ctb_pkg::ValW-1:0] periods [5];
    periods[0] = 15'd1;
    periods[1] = 15'd32767;
    periods[2] = 15'd0;
    periods[3] = ctb_pkg::ValW'($urandom_range(2, 24));
    periods[4] = ctb_pkg::SNOOZE_RST;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset snooze period
    send_txn(ctb_pkg::OP_SNOOZE, 4'd0,  15'd0);
    send_txn(ctb_pkg::OP_TICK,   4'd0,  15'd0);
    send_txn(ctb_pkg::OP_LOAD,   4'd0,  15'd0);
    send_txn(ctb_pkg::OP_LOAD,   4'd15, 15'd32767);
    send_txn(ctb_pkg::OP_LOAD,   4'd7,  15'd1);
    send_txn(ctb_pkg::OP_TICK,   4'd15, 15'd32767);
    send_txn(ctb_pkg::OP_SNOOZE, 4'd0,  15'd0);
    send_txn(ctb_pkg::OP_SNOOZE, 4'd0,  15'd0);
    send_txn(ctb_pkg::OP_LOAD,   4'd3,  15'd0);
    send_txn(ctb_pkg::OP_CLEAR,  4'd3,  15'd0);
    send_txn(ctb_pkg::OP_CLEAR,  4'd15, 15'd0);
    send_txn(ctb_pkg::OP_CLEAR,  4'd9,  15'd0);
    send_txn(ctb_pkg::OP_LOAD,   4'd0,  15'd2);
    send_txn(ctb_pkg::OP_LOAD,   4'd5,  15'd0);
    send_txn(ctb_pkg::OP_LOAD,   4'd5,  15'h5555);
    send_txn(ctb_pkg::OP_LOAD,   4'd6,  15'h2AAA);
    send_txn(ctb_pkg::OP_TICK,   4'd0,  15'd0);
    in_valid_i <= 1'b0;
    drain();

    // zero period keeps the timer expired
    write_snooze(15'd0);
    send_txn(ctb_pkg::OP_LOAD,   4'd2,  15'd0);
    send_txn(ctb_pkg::OP_SNOOZE, 4'd0,  15'd0);
    in_valid_i <= 1'b0;
    drain();

    write_snooze(15'd32767);
    send_txn(ctb_pkg::OP_SNOOZE, 4'd0,  15'd0);
    send_txn(ctb_pkg::OP_TICK,   4'd0,  15'd0);
    in_valid_i <= 1'b0;
    drain();

    for (int p = 0; p < 5; p++) begin
      write_snooze(periods[p]);
      calm = (p == 1);
      repeat (ItemsPerPhase) send_random();
      in_valid_i <= 1'b0;
      drain();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ctb_pkg.sv
rtl/ctb_alu.sv
rtl/ctb_store.sv
rtl/countdown_timer_bank_with_snooze.sv
rtl/ctb_checker.sv
dv/timer_bank_checker.sv
dv/tb_countdown_timer_bank_with_snooze.sv
